// ===== rtl/bls_pkg.sv =====
package bls_pkg;

    // width of the color word carried with every pixel
    localparam int COLOR_BITS = 32;

    // extra bits of the error term above the coordinate width
    localparam int ERR_EXTRA_BITS = 2;

    // depth of the queue between front and back
    localparam int CMD_QUEUE_DEPTH = 2;

    // request kinds as they arrive on the request channel
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } t_req_kind;

endpackage

// ===== rtl/bls_if.sv =====
// request channel: start or tick beats
interface bls_req_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        pen_color;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

// pixel channel: one beat per emitted pixel
interface bls_pix_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pix_x;
    logic signed [COORD_BITS-1:0] pix_y;
    logic [COLOR_BITS-1:0]        pix_color;
    logic                         last;

    modport source (
        output valid, pix_x, pix_y, pix_color, last,
        input  ready
    );
    modport sink (
        input  valid, pix_x, pix_y, pix_color, last,
        output ready
    );
endinterface

// ===== rtl/bls_front.sv =====
module bls_front
    import bls_pkg::*;
#(
    parameter int  COORD_BITS = 12,
    parameter type t_cmd      = logic
) (
    bls_req_if.sink i_req,
    output logic    o_cmd_valid,
    output t_cmd    o_cmd,
    input  logic    i_cmd_ready
);

    logic signed [COORD_BITS:0]   w_dx_signed;
    logic signed [COORD_BITS:0]   w_dy_signed;
    logic signed [COORD_BITS:0]   w_dx_negated;
    logic signed [COORD_BITS:0]   w_dy_negated;
    logic [COORD_BITS-1:0]        w_dx_abs;
    logic [COORD_BITS-1:0]        w_dy_abs;

    // endpoint differences, one bit wider so they cannot wrap
    assign w_dx_signed  = {i_req.end_x[COORD_BITS-1], i_req.end_x}
                        - {i_req.start_x[COORD_BITS-1], i_req.start_x};
    assign w_dy_signed  = {i_req.end_y[COORD_BITS-1], i_req.end_y}
                        - {i_req.start_y[COORD_BITS-1], i_req.start_y};
    assign w_dx_negated = -w_dx_signed;
    assign w_dy_negated = -w_dy_signed;

    // magnitudes always fit the coordinate width
    assign w_dx_abs = w_dx_signed[COORD_BITS] ? w_dx_negated[COORD_BITS-1:0]
                                              : w_dx_signed[COORD_BITS-1:0];
    assign w_dy_abs = w_dy_signed[COORD_BITS] ? w_dy_negated[COORD_BITS-1:0]
                                              : w_dy_signed[COORD_BITS-1:0];

    // classify the beat and build the line setup for the back end
    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = i_req.req_type ? REQ_TICK : REQ_START;
        o_cmd.x1         = i_req.start_x;
        o_cmd.y1         = i_req.start_y;
        o_cmd.x2         = i_req.end_x;
        o_cmd.y2         = i_req.end_y;
        o_cmd.dx         = w_dx_abs;
        o_cmd.dy         = w_dy_abs;
        o_cmd.sx_neg     = !(i_req.start_x < i_req.end_x);
        o_cmd.sy_neg     = !(i_req.start_y < i_req.end_y);
        o_cmd.err        = signed'({{ERR_EXTRA_BITS{1'b0}}, w_dx_abs})
                         - signed'({{ERR_EXTRA_BITS{1'b0}}, w_dy_abs});
        o_cmd.first_last = (i_req.start_x == i_req.end_x)
                        && (i_req.start_y == i_req.end_y);
        o_cmd.color      = i_req.pen_color;
    end

    // handshake passes to the queue
    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

endmodule

// ===== rtl/bls_fifo.sv =====
module bls_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/bls_back.sv =====
module bls_back
    import bls_pkg::*;
#(
    parameter int  COORD_BITS = 12,
    parameter type t_cmd      = logic
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    bls_pix_if.source  o_pix
);

    localparam int ERR_BITS = COORD_BITS + ERR_EXTRA_BITS;
    localparam int E2_BITS  = ERR_BITS + 1;

    // line state
    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_target_x;
    logic signed [COORD_BITS-1:0] r_target_y;
    logic [COORD_BITS-1:0]        r_delta_x;
    logic [COORD_BITS-1:0]        r_delta_y;
    logic                         r_step_x_neg;
    logic                         r_step_y_neg;
    logic signed [ERR_BITS-1:0]   r_error;
    logic [COLOR_BITS-1:0]        r_color;
    logic                         r_active;

    // output register
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    logic [COLOR_BITS-1:0]        r_out_color;
    logic                         r_out_last;

    logic signed [COORD_BITS-1:0] n_cur_x;
    logic signed [COORD_BITS-1:0] n_cur_y;
    logic signed [ERR_BITS-1:0]   n_error;
    logic                         n_last;

    logic signed [E2_BITS-1:0]    w_e2;
    logic signed [E2_BITS-1:0]    w_dx_ext;
    logic signed [E2_BITS-1:0]    w_neg_dy;
    logic                         w_move_x;
    logic                         w_move_y;
    logic                         w_is_tick;
    logic                         w_emit;
    logic                         w_out_free;
    logic                         w_fire;

    // beat classification and pop control
    assign w_is_tick   = (i_cmd.kind == REQ_TICK);
    assign w_out_free  = !r_out_valid || o_pix.ready;
    assign o_cmd_ready = w_out_free || (w_is_tick && !r_active);
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign w_emit      = w_fire && (!w_is_tick || r_active);

    // all-octant error test on the doubled error
    assign w_e2     = {r_error, 1'b0};
    assign w_dx_ext = signed'({{(E2_BITS - COORD_BITS){1'b0}}, r_delta_x});
    assign w_neg_dy = -signed'({{(E2_BITS - COORD_BITS){1'b0}}, r_delta_y});
    assign w_move_x = (w_e2 > w_neg_dy);
    assign w_move_y = (w_e2 < w_dx_ext);

    // next pixel and error for a tick
    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_error = r_error;
        if (w_move_x) begin
            n_cur_x = r_step_x_neg ? r_cur_x - COORD_BITS'(1) : r_cur_x + COORD_BITS'(1);
            n_error = n_error - signed'({{ERR_EXTRA_BITS{1'b0}}, r_delta_y});
        end
        if (w_move_y) begin
            n_cur_y = r_step_y_neg ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);
            n_error = n_error + signed'({{ERR_EXTRA_BITS{1'b0}}, r_delta_x});
        end
        n_last = (n_cur_x == r_target_x) && (n_cur_y == r_target_y);
    end

    // walker control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_emit) begin
            r_active <= w_is_tick ? !n_last : !i_cmd.first_last;
        end
    end

    // walker datapath
    always_ff @(posedge i_clk) begin
        if (w_emit && !w_is_tick) begin
            r_cur_x      <= i_cmd.x1;
            r_cur_y      <= i_cmd.y1;
            r_target_x   <= i_cmd.x2;
            r_target_y   <= i_cmd.y2;
            r_delta_x    <= i_cmd.dx;
            r_delta_y    <= i_cmd.dy;
            r_step_x_neg <= i_cmd.sx_neg;
            r_step_y_neg <= i_cmd.sy_neg;
            r_error      <= i_cmd.err;
            r_color      <= i_cmd.color;
        end else if (w_emit) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_error <= n_error;
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (w_emit && !w_is_tick) begin
            r_out_x     <= i_cmd.x1;
            r_out_y     <= i_cmd.y1;
            r_out_color <= i_cmd.color;
            r_out_last  <= i_cmd.first_last;
        end else if (w_emit) begin
            r_out_x     <= n_cur_x;
            r_out_y     <= n_cur_y;
            r_out_color <= r_color;
            r_out_last  <= n_last;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pix_x     = r_out_x;
    assign o_pix.pix_y     = r_out_y;
    assign o_pix.pix_color = r_out_color;
    assign o_pix.last      = r_out_last;

endmodule

// ===== rtl/bresenham_line_stepper.sv =====
// Bresenham line stepper
//
// i_req carries request beats: req_type 0 starts a line from start_x/start_y
// to end_x/end_y in pen_color, req_type 1 is a tick that asks for the next
// pixel. o_pix carries one beat per pixel with its color; the beat of the
// second endpoint has last set, after which the walker is idle. A start emits
// the first endpoint at once; a tick while idle emits nothing. A start during
// a line drops that line. Pixels are not clipped.
//
// A request accepted at i_req passes the queue and the pixel register on
// its way to o_pix. Throughput: one request and one pixel per clock while
// the sink takes beats; the walker steps by a combinational add and compare.
// A two-beat queue parts the request side from the walker, and the pixel
// register parts the walker from the sink, so a stalled sink fills the queue
// and then holds i_req.ready low; the pixel beat holds until taken.
// Reset (i_rst_n low, synchronous) empties the queue, drops the output beat
// and leaves the walker idle.
module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_req_if.sink   i_req,
    bls_pix_if.source o_pix
);

    localparam int ERR_BITS = COORD_BITS + ERR_EXTRA_BITS;

    // classified request handed from front to back
    typedef struct packed {
        t_req_kind                    kind;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic [COORD_BITS-1:0]        dx;
        logic [COORD_BITS-1:0]        dy;
        logic                         sx_neg;
        logic                         sy_neg;
        logic signed [ERR_BITS-1:0]   err;
        logic [COLOR_BITS-1:0]        color;
        logic                         first_last;
    } t_cmd;

    localparam int CMD_BITS = $bits(t_cmd);

    logic             w_front_valid;
    t_cmd             w_front_cmd;
    logic             w_queue_full;
    logic             w_queue_valid;
    logic [CMD_BITS-1:0] w_queue_data;
    logic             w_back_ready;

    // front: setup of deltas, signs and error term
    bls_front #(
        .COORD_BITS (COORD_BITS),
        .t_cmd      (t_cmd)
    ) u_front (
        .i_req       (i_req),
        .o_cmd_valid (w_front_valid),
        .o_cmd       (w_front_cmd),
        .i_cmd_ready (!w_queue_full)
    );

    // queue between front and back
    bls_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_cmd),
        .o_full  (w_queue_full),
        .i_pop   (w_back_ready),
        .o_valid (w_queue_valid),
        .o_data  (w_queue_data)
    );

    // back: line walker and pixel register
    bls_back #(
        .COORD_BITS (COORD_BITS),
        .t_cmd      (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (t_cmd'(w_queue_data)),
        .o_cmd_ready (w_back_ready),
        .o_pix       (o_pix)
    );

endmodule

// ===== rtl/bls_checker.sv =====
module bls_checker
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_ready,
    input logic                  i_pix_valid,
    input logic                  i_pix_ready,
    input logic [COORD_BITS-1:0] i_pix_x,
    input logic [COORD_BITS-1:0] i_pix_y,
    input logic [COLOR_BITS-1:0] i_pix_color,
    input logic                  i_pix_last
);

    // a stalled pixel beat holds its payload
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid && $stable(i_pix_x)
            && $stable(i_pix_y) && $stable(i_pix_color) && $stable(i_pix_last))
        else $error("pixel beat changed while stalled");

    // reset leaves no pixel beat pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid)
        else $error("pixel beat valid right after reset");

    // reset leaves the queue empty and open for requests
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_req_ready)
        else $error("request side not ready after reset");

    // with the sink taking beats the queue never fills
    a_full_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready && i_pix_ready |=> i_req_ready)
        else $error("request side stalled while sink was ready");

endmodule

bind bresenham_line_stepper bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_x     (o_pix.pix_x),
    .i_pix_y     (o_pix.pix_y),
    .i_pix_color (o_pix.pix_color),
    .i_pix_last  (o_pix.last)
);

// ===== tb/bresenham_line_stepper_tb.sv =====
module bresenham_line_stepper_tb;
    import bls_pkg::*;

    localparam int CB        = 12;
    localparam int COORD_MAX = 2 ** (CB - 1) - 1;
    localparam int COORD_MIN = -(2 ** (CB - 1));

    typedef struct {
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bls_req_if #(.COORD_BITS(CB)) req_bus ();
    bls_pix_if #(.COORD_BITS(CB)) pix_bus ();

    bresenham_line_stepper #(.COORD_BITS(CB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_pix   (pix_bus)
    );

    always #2 i_clk = ~i_clk;

    // pixels still owed by the block, oldest first
    t_pixel expected_pixels[$];
    int     pixels_issued  = 0;
    int     mismatch_count = 0;

    // idle control for both sides and the long sink hold-off
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_len     = 0;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    // walker state as the predictor tracks it
    logic signed [CB-1:0]  walk_x     = '0;
    logic signed [CB-1:0]  walk_y     = '0;
    logic signed [CB-1:0]  goal_x     = '0;
    logic signed [CB-1:0]  goal_y     = '0;
    logic [CB-1:0]         span_x     = '0;
    logic [CB-1:0]         span_y     = '0;
    logic                  neg_x      = 1'b0;
    logic                  neg_y      = 1'b0;
    logic signed [CB+1:0]  err_acc    = '0;
    logic [COLOR_BITS-1:0] walk_color = '0;
    logic                  walking    = 1'b0;

    // next pixel of the walk for one request, if the request yields one
    function automatic bit predict_pixel(input t_req_kind kind,
                                         input logic signed [CB-1:0] sx, sy, ex, ey,
                                         input logic [COLOR_BITS-1:0] color,
                                         output t_pixel px);
        int dx;
        int dy;
        int err;
        int e2;
        bit at_goal;
        if (kind == REQ_START) begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            walk_x     = sx;
            walk_y     = sy;
            goal_x     = ex;
            goal_y     = ey;
            span_x     = CB'((dx < 0) ? -dx : dx);
            span_y     = CB'((dy < 0) ? -dy : dy);
            neg_x      = !(sx < ex);
            neg_y      = !(sy < ey);
            err_acc    = (CB+2)'(int'(span_x) - int'(span_y));
            walk_color = color;
        end else begin
            if (!walking)
                return 1'b0;
            err = int'(err_acc);
            e2  = 2 * err;
            if (e2 > -int'(span_y)) begin
                err    = err - int'(span_y);
                walk_x = neg_x ? walk_x - 12'sd1 : walk_x + 12'sd1;
            end
            if (e2 < int'(span_x)) begin
                err    = err + int'(span_x);
                walk_y = neg_y ? walk_y - 12'sd1 : walk_y + 12'sd1;
            end
            err_acc = (CB+2)'(err);
        end
        at_goal  = (walk_x == goal_x) && (walk_y == goal_y);
        walking  = !at_goal;
        px.x     = walk_x;
        px.y     = walk_y;
        px.color = walk_color;
        px.last  = at_goal;
        return 1'b1;
    endfunction

    // coordinate near base, kept inside the signed range
    function automatic logic signed [CB-1:0] near_coord(input logic signed [CB-1:0] base,
                                                        input int reach);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[CB-1:0];
    endfunction

    // offer one request beat, wait for it to be taken, then predict
    task automatic send_request(input t_req_kind kind,
                                input logic signed [CB-1:0] sx, sy, ex, ey,
                                input logic [COLOR_BITS-1:0] color);
        t_pixel px;
        if (src_idle_on) begin
            while ($urandom_range(0, 99) < 16) begin
                req_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= kind;
        req_bus.start_x   <= sx;
        req_bus.start_y   <= sy;
        req_bus.end_x     <= ex;
        req_bus.end_y     <= ey;
        req_bus.pen_color <= color;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        if (predict_pixel(kind, sx, sy, ex, ey, color, px)) begin
            expected_pixels.push_back(px);
            pixels_issued++;
        end
    endtask

    // tick with junk in the ignored fields
    task automatic send_tick();
        send_request(REQ_TICK, CB'($urandom), CB'($urandom),
                     CB'($urandom), CB'($urandom), $urandom);
    endtask

    // sender stops until every owed pixel has come back
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one line with random endpoints, walked out or dropped partway
    task automatic walk_random_line();
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        int dxa;
        int dya;
        int span;
        int n_ticks;
        sx = CB'($urandom);
        sy = CB'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            ex = CB'($urandom);
            ey = CB'($urandom);
        end else begin
            ex = near_coord(sx, $urandom_range(0, 12));
            ey = near_coord(sy, $urandom_range(0, 12));
        end
        dxa  = int'(ex) - int'(sx);
        dya  = int'(ey) - int'(sy);
        dxa  = (dxa < 0) ? -dxa : dxa;
        dya  = (dya < 0) ? -dya : dya;
        span = (dxa > dya) ? dxa : dya;
        if ($urandom_range(0, 7) == 0)
            n_ticks = $urandom_range(0, (span > 30) ? 30 : span);
        else if (span > 60)
            n_ticks = $urandom_range(0, 30);
        else
            n_ticks = span + $urandom_range(0, 2);
        send_request(REQ_START, sx, sy, ex, ey, $urandom);
        repeat (n_ticks) send_tick();
    endtask

    // ticks straight after reset must yield nothing
    task automatic check_idle_ticks();
        repeat (3) send_tick();
    endtask

    // hand-picked lines: single point, axes, steep, extremes, restart
    task automatic check_directed_lines();
        send_request(REQ_START, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 32'h0000_0000);
        send_tick();
        send_request(REQ_START, 12'sd0, 12'sd0, 12'sd3, 12'sd0, 32'h1234_5678);
        repeat (3) send_tick();
        send_request(REQ_START, 12'sd0, 12'sd0, 12'sd0, -12'sd3, 32'h8765_4321);
        repeat (3) send_tick();
        send_request(REQ_START, 12'sd1, 12'sd1, -12'sd1, -12'sd4, 32'hDEAD_BEEF);
        repeat (5) send_tick();
        send_request(REQ_START, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 32'hFFFF_FFFF);
        repeat (2) send_tick();
        send_request(REQ_START, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, 32'h0000_0000);
        repeat (2) send_tick();
        send_request(REQ_START, 12'sd2047, -12'sd2048, 12'sd2047, -12'sd2048, 32'hA5A5_5A5A);
    endtask

    // random lines until n more pixels are owed
    task automatic check_random_lines(input int n);
        int goal;
        goal = pixels_issued + n;
        while (pixels_issued < goal)
            walk_random_line();
    endtask

    // back-to-back beats on both sides
    task automatic check_steady_stream();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        check_random_lines(200);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // sink holds off while ticks keep coming, so the block backs up
    task automatic check_sink_stall();
        send_request(REQ_START, -12'sd2000, -12'sd1500, 12'sd2000, 12'sd1500, $urandom);
        hold_len = 120;
        hold_seq++;
        repeat (40) send_tick();
        wait_drained();
    endtask

    // sink ready, with random idles and the long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            pix_bus.ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen     <= hold_seq;
            hold_left     <= hold_len;
            pix_bus.ready <= 1'b0;
        end else begin
            pix_bus.ready <= !(sink_idle_on && $urandom_range(0, 99) < 16);
        end
    end

    // compare each pixel beat with the oldest owed pixel
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel beat at x %0d y %0d", pix_bus.pix_x, pix_bus.pix_y);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (pix_bus.pix_x !== want.x) begin
                    $error("pix_x mismatch: expected %0d, got %0d", want.x, pix_bus.pix_x);
                    mismatch_count++;
                end
                if (pix_bus.pix_y !== want.y) begin
                    $error("pix_y mismatch: expected %0d, got %0d", want.y, pix_bus.pix_y);
                    mismatch_count++;
                end
                if (pix_bus.pix_color !== want.color) begin
                    $error("pix_color mismatch: expected %h, got %h",
                           want.color, pix_bus.pix_color);
                    mismatch_count++;
                end
                if (pix_bus.last !== want.last) begin
                    $error("last mismatch: expected %b, got %b", want.last, pix_bus.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_TICK;
        req_bus.start_x   <= '0;
        req_bus.start_y   <= '0;
        req_bus.end_x     <= '0;
        req_bus.end_y     <= '0;
        req_bus.pen_color <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_idle_ticks();
        check_directed_lines();
        check_random_lines(1000);
        check_steady_stream();
        check_sink_stall();
        check_random_lines(300);

        req_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
